// ===== sv/tiba_pkg.sv =====
// shared constants and types of the temporal band-pass amplifier
`timescale 1ns / 1ps

package tiba_pkg;

    localparam int SW          = 16;
    localparam int STORE_DEPTH = 16384;
    localparam int LEVELS      = 4;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PIX_ADDR_W  = 14;
    localparam int LEVEL_W     = 3;
    localparam int COEF_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int COEF_FRAC   = 16;
    localparam int GAIN_FRAC   = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int IN_DATA_W   = ((PIX_ADDR_W + 3 * SW + 7) / 8) * 8;
    localparam int IN_USER_W   = 1 + LEVEL_W;
    localparam int OUT_DATA_W  = ((3 * SW + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_HIGH_CUTOFF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_CUTOFF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ONE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_TWO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_THREE  = 3'd5;

    localparam logic [COEF_W-1:0] HIGH_CUTOFF_RESET = 16'd26214;
    localparam logic [COEF_W-1:0] LOW_CUTOFF_RESET  = 16'd3277;
    localparam logic [COEF_W-1:0] CHROMA_RESET      = 16'd6554;
    localparam logic [GAIN_W-1:0] GAIN_RESET        = 16'd2560;

    typedef logic signed [SW-1:0] sample_t;
    typedef sample_t [2:0] trio_t;

    typedef struct packed {
        logic [COEF_W-1:0] high_cutoff_coef;
        logic [COEF_W-1:0] low_cutoff_coef;
        logic [COEF_W-1:0] chroma_factor;
        logic [GAIN_W-1:0] gain_level_one;
        logic [GAIN_W-1:0] gain_level_two;
        logic [GAIN_W-1:0] gain_level_three;
    } cfg_t;

    typedef struct packed {
        logic               first;
        logic [LEVEL_W-1:0] level;
        logic [ADDR_W-1:0]  addr;
        trio_t              chan;
    } item_t;

    typedef struct packed {
        logic               valid;
        logic               first;
        logic [LEVEL_W-1:0] level;
        trio_t              fast;
        trio_t              slow;
    } state_t;

endpackage

// ===== sv/tiba_lowpass.sv =====
// state stores and the per-channel fast and slow low-pass update stage
`timescale 1ns / 1ps

module tiba_lowpass (
    input  logic              aclk,
    input  logic              aresetn,
    input  tiba_pkg::cfg_t    cfg,
    input  logic              adv,
    input  logic              in_valid,
    input  tiba_pkg::item_t   in_item,
    output tiba_pkg::state_t  st_out
);

    localparam int LP_W = tiba_pkg::COEF_W + tiba_pkg::SW + 2;
    localparam int HALF = 1 << (tiba_pkg::COEF_FRAC - 1);

    tiba_pkg::trio_t  fast_mem [tiba_pkg::STORE_DEPTH];
    tiba_pkg::trio_t  slow_mem [tiba_pkg::STORE_DEPTH];

    logic             s1_valid_reg;
    tiba_pkg::item_t  s1_item_reg;
    tiba_pkg::trio_t  rd_fast_reg;
    tiba_pkg::trio_t  rd_slow_reg;
    tiba_pkg::trio_t  fast_next;
    tiba_pkg::trio_t  slow_next;
    tiba_pkg::state_t st_reg;
    logic             rd_en;
    logic             wr_en;

    function automatic tiba_pkg::sample_t lowpass(input tiba_pkg::sample_t old,
                                                  input tiba_pkg::sample_t x,
                                                  input logic [tiba_pkg::COEF_W-1:0] c);
        logic signed [tiba_pkg::SW:0] d;
        logic signed [LP_W-1:0]       p;
        logic signed [LP_W-1:0]       r;
        logic signed [tiba_pkg::SW:0] sum;
        d   = (tiba_pkg::SW + 1)'(x) - (tiba_pkg::SW + 1)'(old);
        p   = LP_W'($signed({1'b0, c})) * LP_W'(d);
        r   = (p + LP_W'(HALF)) >>> tiba_pkg::COEF_FRAC;
        sum = (tiba_pkg::SW + 1)'(old) + r[tiba_pkg::SW:0];
        return sum[tiba_pkg::SW-1:0];
    endfunction

    assign rd_en = adv && in_valid;
    assign wr_en = adv && s1_valid_reg;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            if (s1_item_reg.first) begin
                fast_next[ch] = s1_item_reg.chan[ch];
                slow_next[ch] = s1_item_reg.chan[ch];
            end else begin
                fast_next[ch] = lowpass(rd_fast_reg[ch], s1_item_reg.chan[ch],
                                        cfg.high_cutoff_coef);
                slow_next[ch] = lowpass(rd_slow_reg[ch], s1_item_reg.chan[ch],
                                        cfg.low_cutoff_coef);
            end
        end
    end

    // read with bypass from the write of the same edge
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fast_mem[s1_item_reg.addr] <= fast_next;
            slow_mem[s1_item_reg.addr] <= slow_next;
        end
        if (rd_en) begin
            if (wr_en && (s1_item_reg.addr == in_item.addr)) begin
                rd_fast_reg <= fast_next;
                rd_slow_reg <= slow_next;
            end else begin
                rd_fast_reg <= fast_mem[in_item.addr];
                rd_slow_reg <= slow_mem[in_item.addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            st_reg.valid <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            st_reg.valid <= s1_valid_reg;
        end
        if (adv) begin
            s1_item_reg  <= in_item;
            st_reg.first <= s1_item_reg.first;
            st_reg.level <= s1_item_reg.level;
            st_reg.fast  <= fast_next;
            st_reg.slow  <= slow_next;
        end
    end

    assign st_out = st_reg;

endmodule

// ===== sv/tiba_amplify.sv =====
// band-pass difference, level gain, chroma scaling and saturation stages
`timescale 1ns / 1ps

module tiba_amplify (
    input  logic             aclk,
    input  logic             aresetn,
    input  tiba_pkg::cfg_t   cfg,
    input  logic             adv,
    input  tiba_pkg::state_t st_in,
    output logic             out_valid,
    output tiba_pkg::trio_t  out_data
);

    localparam int BP_W  = tiba_pkg::SW + 1 + tiba_pkg::GAIN_W + 1;
    localparam int Y1_W  = BP_W - tiba_pkg::GAIN_FRAC;
    localparam int CP_W  = Y1_W + tiba_pkg::COEF_W + 1;
    localparam int Y2_W  = CP_W - tiba_pkg::COEF_FRAC;
    localparam int GHALF = 1 << (tiba_pkg::GAIN_FRAC - 1);
    localparam int CHALF = 1 << (tiba_pkg::COEF_FRAC - 1);

    localparam logic signed [Y2_W-1:0] SAT_MAX =
        {{(Y2_W - tiba_pkg::SW + 1){1'b0}}, {(tiba_pkg::SW - 1){1'b1}}};
    localparam logic signed [Y2_W-1:0] SAT_MIN = ~SAT_MAX;

    typedef logic signed [Y1_W-1:0] y1_t;
    typedef logic signed [Y2_W-1:0] y2_t;

    logic                        s3_valid_reg;
    logic                        s3_first_reg;
    y1_t                         s3_y_reg [3];
    logic                        s4_valid_reg;
    logic                        s4_first_reg;
    y2_t                         s4_y_reg [3];
    logic [tiba_pkg::GAIN_W-1:0] gain;
    y1_t                         y1_next [3];
    y2_t                         y2_next [3];

    function automatic logic [tiba_pkg::GAIN_W-1:0] level_gain(
            input logic [tiba_pkg::LEVEL_W-1:0] lvl);
        logic [tiba_pkg::GAIN_W-1:0] g;
        priority if (lvl == '0 || int'(lvl) >= tiba_pkg::LEVELS) begin
            g = '0;
        end else if (int'(lvl) == 1) begin
            g = cfg.gain_level_one;
        end else if (int'(lvl) == 2) begin
            g = cfg.gain_level_two;
        end else begin
            g = cfg.gain_level_three;
        end
        return g;
    endfunction

    function automatic y1_t apply_gain(input tiba_pkg::sample_t f,
                                       input tiba_pkg::sample_t s,
                                       input logic [tiba_pkg::GAIN_W-1:0] g);
        logic signed [tiba_pkg::SW:0] band;
        logic signed [BP_W-1:0]       p;
        logic signed [BP_W-1:0]       r;
        band = (tiba_pkg::SW + 1)'(f) - (tiba_pkg::SW + 1)'(s);
        p    = BP_W'(band) * BP_W'($signed({1'b0, g}));
        r    = (p + BP_W'(GHALF)) >>> tiba_pkg::GAIN_FRAC;
        return r[Y1_W-1:0];
    endfunction

    function automatic y2_t apply_chroma(input y1_t y,
                                         input logic [tiba_pkg::COEF_W-1:0] c);
        logic signed [CP_W-1:0] p;
        logic signed [CP_W-1:0] r;
        p = CP_W'(y) * CP_W'($signed({1'b0, c}));
        r = (p + CP_W'(CHALF)) >>> tiba_pkg::COEF_FRAC;
        return r[Y2_W-1:0];
    endfunction

    function automatic tiba_pkg::sample_t saturate(input y2_t v);
        tiba_pkg::sample_t o;
        priority if (v > SAT_MAX) begin
            o = SAT_MAX[tiba_pkg::SW-1:0];
        end else if (v < SAT_MIN) begin
            o = SAT_MIN[tiba_pkg::SW-1:0];
        end else begin
            o = v[tiba_pkg::SW-1:0];
        end
        return o;
    endfunction

    assign gain = level_gain(st_in.level);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            y1_next[ch] = apply_gain(st_in.fast[ch], st_in.slow[ch], gain);
        end
        y2_next[0] = Y2_W'(s3_y_reg[0]);
        for (int ch = 1; ch < 3; ch++) begin
            y2_next[ch] = apply_chroma(s3_y_reg[ch], cfg.chroma_factor);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= st_in.valid;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_first_reg <= st_in.first;
            s4_first_reg <= s3_first_reg;
            for (int ch = 0; ch < 3; ch++) begin
                s3_y_reg[ch] <= y1_next[ch];
                s4_y_reg[ch] <= y2_next[ch];
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            out_data[ch] = s4_first_reg ? '0 : saturate(s4_y_reg[ch]);
        end
    end

    assign out_valid = s4_valid_reg;

endmodule

// ===== sv/tiba_out_fifo.sv =====
// two-entry output buffer between the pipeline and the result channel
`timescale 1ns / 1ps

module tiba_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tiba_pkg::trio_t din,
    output logic            space,
    output logic            m_tvalid,
    input  logic            m_tready,
    output tiba_pkg::trio_t dout
);

    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    tiba_pkg::trio_t ent0_reg;
    tiba_pkg::trio_t ent1_reg;
    logic            pop;
    logic [1:0]      wpos;

    assign pop        = m_tvalid && m_tready;
    assign wpos       = count_reg - {1'b0, pop};
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && wpos == 2'd0) begin
            ent0_reg <= din;
        end else if (pop) begin
            ent0_reg <= ent1_reg;
        end
        if (push && wpos == 2'd1) begin
            ent1_reg <= din;
        end
    end

    assign space    = (count_reg != 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign dout     = ent0_reg;

endmodule

// ===== sv/temporal_iir_bandpass_amplify.sv =====
// temporal band-pass amplifier: one pixel per cycle while the buffer has room
// a result passes the s1, state, s3 and s4 registers and the output buffer
// the state update closes through the store read bypass
// a 2-entry output buffer keeps input open while results wait
// reset (aresetn low, synchronous) clears valids and loads register defaults
// filter stores are not cleared; each address starts with a first-frame pixel
`timescale 1ns / 1ps

module temporal_iir_bandpass_amplify (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pixel_address, chan_l, chan_a, chan_b, zero pad
    input  logic [tiba_pkg::IN_DATA_W-1:0]      s_tdata,
    // first_frame, level
    input  logic [tiba_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // band_l, band_a, band_b
    output logic [tiba_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tiba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tiba_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CH0 = tiba_pkg::PIX_ADDR_W;
    localparam int CH1 = CH0 + tiba_pkg::SW;
    localparam int CH2 = CH1 + tiba_pkg::SW;

    tiba_pkg::cfg_t   cfg_reg;
    tiba_pkg::item_t  in_item;
    tiba_pkg::state_t st;
    tiba_pkg::trio_t  amp_data;
    tiba_pkg::trio_t  out_data;
    logic             amp_valid;
    logic             adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.high_cutoff_coef <= tiba_pkg::HIGH_CUTOFF_RESET;
            cfg_reg.low_cutoff_coef  <= tiba_pkg::LOW_CUTOFF_RESET;
            cfg_reg.chroma_factor    <= tiba_pkg::CHROMA_RESET;
            cfg_reg.gain_level_one   <= tiba_pkg::GAIN_RESET;
            cfg_reg.gain_level_two   <= tiba_pkg::GAIN_RESET;
            cfg_reg.gain_level_three <= tiba_pkg::GAIN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tiba_pkg::REG_HIGH_CUTOFF: cfg_reg.high_cutoff_coef <= cfg_data;
                tiba_pkg::REG_LOW_CUTOFF:  cfg_reg.low_cutoff_coef  <= cfg_data;
                tiba_pkg::REG_CHROMA:      cfg_reg.chroma_factor    <= cfg_data;
                tiba_pkg::REG_GAIN_ONE:    cfg_reg.gain_level_one   <= cfg_data;
                tiba_pkg::REG_GAIN_TWO:    cfg_reg.gain_level_two   <= cfg_data;
                tiba_pkg::REG_GAIN_THREE:  cfg_reg.gain_level_three <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.first   = s_tuser[0];
    assign in_item.level   = s_tuser[tiba_pkg::LEVEL_W:1];
    assign in_item.addr    = tiba_pkg::ADDR_W'(s_tdata[tiba_pkg::PIX_ADDR_W-1:0]);
    assign in_item.chan[0] = s_tdata[CH0 +: tiba_pkg::SW];
    assign in_item.chan[1] = s_tdata[CH1 +: tiba_pkg::SW];
    assign in_item.chan[2] = s_tdata[CH2 +: tiba_pkg::SW];

    assign s_tready = adv;

    tiba_lowpass u_lowpass (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .adv      (adv),
        .in_valid (s_tvalid),
        .in_item  (in_item),
        .st_out   (st)
    );

    tiba_amplify u_amplify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .adv       (adv),
        .st_in     (st),
        .out_valid (amp_valid),
        .out_data  (amp_data)
    );

    tiba_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (amp_valid && adv),
        .din      (amp_data),
        .space    (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dout     (out_data)
    );

    assign m_tdata = tiba_pkg::OUT_DATA_W'({out_data[2], out_data[1], out_data[0]});

`ifndef NO_ASSERTIONS
    assert property (@(posedge aclk) disable iff (!aresetn) !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && !s_tready) |=> !s_tready)
        else $error("input opened while output buffer full and not drained");
`endif

endmodule
